>>> design/gbts_pkg.sv
// Shared definitions for the gap buffer text store.
// Field widths, operation and status codes, default capacity. No dependencies.
`default_nettype none

package gbts_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 1024;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_DELETE = 2'd1;
  localparam func_t FUNC_MOVE   = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_START  = 2'd2;
  localparam status_t ST_BEYOND = 2'd3;

endpackage

`default_nettype wire

>>> design/gbts_if.sv
// Valid/ready channel interfaces for the gap buffer text store.
// Depends on gbts_pkg for field widths.
`default_nettype none

interface gbts_request_if;
  logic                        valid;
  logic                        ready;
  logic [gbts_pkg::FUNC_W-1:0] func;
  logic [gbts_pkg::CHAR_W-1:0] char_in;
  logic [gbts_pkg::POS_W-1:0]  position;

  modport source (output valid, func, char_in, position, input ready);
  modport sink   (input valid, func, char_in, position, output ready);
endinterface

interface gbts_result_if;
  logic                          valid;
  logic                          ready;
  logic [gbts_pkg::STATUS_W-1:0] status;
  logic [gbts_pkg::POS_W-1:0]    cursor;
  logic [gbts_pkg::POS_W-1:0]    text_length;
  logic [gbts_pkg::CHAR_W-1:0]   char_before_cursor;

  modport source (output valid, status, cursor, text_length, char_before_cursor,
                  input ready);
  modport sink   (input valid, status, cursor, text_length, char_before_cursor,
                  output ready);
endinterface

`default_nettype wire

>>> design/gap_buffer_text_store_core.sv
// Gap buffer text store: top level, text memory and gap move sequencer.
// Depends on gbts_pkg and the channel interfaces in gbts_if.sv.
//
// One request is worked at a time. Insert, delete and the idle code pass
// from acceptance through the read and response states; a gap move first
// copies |position - cursor| bytes in the move state, one byte per cycle
// through the single read port and single write port of the text memory (a
// read, then the write of that byte in the cycle after, overlapped with the
// next read). The result sits in an output register, so the next request is
// taken while it waits. The text memory needs no clearing after reset.
`default_nettype none

module gap_buffer_text_store_core #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  gbts_request_if.sink    request,
  gbts_result_if.source   result
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [gbts_pkg::CHAR_W-1:0] mem [CAPACITY];
  logic [gbts_pkg::CHAR_W-1:0] rd_data;
  logic [AW-1:0]               mem_raddr;
  logic [AW-1:0]               mem_waddr;
  logic [gbts_pkg::CHAR_W-1:0] mem_wdata;
  logic                        mem_we;

  logic [1:0]              state, state_next;
  logic [PW-1:0]           gb, gb_next;
  logic [PW-1:0]           gl, gl_next;
  logic [PW-1:0]           target, target_next;
  logic                    dir, dir_next;
  logic                    wr_pend, wr_pend_next;
  logic [AW-1:0]           wr_addr, wr_addr_next;
  gbts_pkg::status_t       status, status_next;

  logic [PW-1:0]           gb_dec;
  logic [PW-1:0]           gl_dec;
  logic [PW-1:0]           text_len;
  logic [CW-1:0]           pos_ext;
  logic [CW-1:0]           len_ext;
  logic                    req_fire;
  logic                    issue;
  logic                    load_out;

  assign gb_dec   = gb - ONE_P;
  assign gl_dec   = gl - ONE_P;
  assign text_len = CAP_P - (gl - gb);
  assign pos_ext  = CW'(request.position);
  assign len_ext  = CW'(text_len);
  assign req_fire = request.valid && request.ready;
  assign issue    = (state == S_MOVE) && (gb != target);
  assign load_out = (state == S_RESP) && (!result.valid || result.ready);

  assign request.ready = (state == S_IDLE);

  // Text memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_comb begin
    mem_raddr = gb_dec[AW-1:0];
    if (issue) begin
      mem_raddr = dir ? gl[AW-1:0] : gb_dec[AW-1:0];
    end
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = rd_data;
    if (wr_pend) begin
      mem_we = 1'b1;
    end else if (req_fire && request.func == gbts_pkg::FUNC_INSERT && gb != gl) begin
      mem_we    = 1'b1;
      mem_waddr = gb[AW-1:0];
      mem_wdata = request.char_in;
    end
  end

  always_comb begin
    state_next   = state;
    gb_next      = gb;
    gl_next      = gl;
    target_next  = target;
    dir_next     = dir;
    wr_pend_next = issue;
    wr_addr_next = wr_addr;
    status_next  = status;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          status_next = gbts_pkg::ST_OK;
          state_next  = S_READ;
          case (request.func)
            gbts_pkg::FUNC_INSERT: begin
              if (gb == gl) begin
                status_next = gbts_pkg::ST_FULL;
              end else begin
                gb_next = gb + ONE_P;
              end
            end
            gbts_pkg::FUNC_DELETE: begin
              if (gb == '0) begin
                status_next = gbts_pkg::ST_START;
              end else begin
                gb_next = gb_dec;
              end
            end
            gbts_pkg::FUNC_MOVE: begin
              if (pos_ext > len_ext) begin
                status_next = gbts_pkg::ST_BEYOND;
              end else begin
                target_next = pos_ext[PW-1:0];
                dir_next    = (pos_ext[PW-1:0] > gb);
                state_next  = S_MOVE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOVE: begin
        if (issue) begin
          if (dir) begin
            wr_addr_next = gb[AW-1:0];
            gb_next      = gb + ONE_P;
            gl_next      = gl + ONE_P;
          end else begin
            wr_addr_next = gl_dec[AW-1:0];
            gb_next      = gb_dec;
            gl_next      = gl_dec;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      gb      <= '0;
      gl      <= CAP_P;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      gb      <= gb_next;
      gl      <= gl_next;
      wr_pend <= wr_pend_next;
    end
    target  <= target_next;
    dir     <= dir_next;
    wr_addr <= wr_addr_next;
    status  <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.status             <= status;
      result.cursor             <= gbts_pkg::POS_W'(gb);
      result.text_length        <= gbts_pkg::POS_W'(text_len);
      result.char_before_cursor <= (gb == '0) ? '0 : rd_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_gap_order: assert property (@(posedge clk) disable iff (rst) gb <= gl)
    else $error("gap begin past gap limit");
  a_gap_bound: assert property (@(posedge clk) disable iff (rst) gl <= CAP_P)
    else $error("gap limit past capacity");
  a_move_len: assert property (@(posedge clk) disable iff (rst)
      (state == S_MOVE && $past(state) == S_MOVE) |-> (gl - gb) == $past(gl - gb))
    else $error("gap move changed text length");
  a_move_dir: assert property (@(posedge clk) disable iff (rst)
      issue |-> (dir ? (gb < target) : (gb > target)))
    else $error("gap move heading away from target");
`endif

endmodule

`default_nettype wire

>>> test/gap_buffer_text_store_core_test.sv
// Testbench for gap_buffer_text_store_core: drives edit requests, predicts each result.
// Depends on gbts_pkg, gbts_if.sv (channel interfaces) and the core RTL.
`timescale 1ns / 1ps

module gap_buffer_text_store_core_test;

  localparam int unsigned CAPACITY = gbts_pkg::CAPACITY_DEFAULT;
  localparam gbts_pkg::func_t FUNC_IDLE = 2'd3;

  typedef struct packed {
    gbts_pkg::status_t           status;
    logic [gbts_pkg::POS_W-1:0]  cursor;
    logic [gbts_pkg::POS_W-1:0]  text_length;
    logic [gbts_pkg::CHAR_W-1:0] char_before;
  } store_view_t;

  class gap_store_scoreboard;
    logic [gbts_pkg::CHAR_W-1:0] bytes [CAPACITY];
    int unsigned gap_begin;
    int unsigned gap_limit;
    store_view_t expected_views[$];
    int failures;

    function new();
      gap_begin = 0;
      gap_limit = CAPACITY;
      failures = 0;
    endfunction

    function int unsigned text_length();
      return CAPACITY - (gap_limit - gap_begin);
    endfunction

    function int unsigned cursor_at();
      return gap_begin;
    endfunction

    function int unsigned outstanding();
      return expected_views.size();
    endfunction

    function void note_request(gbts_pkg::func_t op, logic [gbts_pkg::CHAR_W-1:0] ch,
                               logic [gbts_pkg::POS_W-1:0] pos);
      store_view_t view;
      view.status = gbts_pkg::ST_OK;
      case (op)
        gbts_pkg::FUNC_INSERT: begin
          if (gap_begin >= gap_limit) begin
            view.status = gbts_pkg::ST_FULL;
          end else begin
            bytes[gap_begin] = ch;
            gap_begin++;
          end
        end
        gbts_pkg::FUNC_DELETE: begin
          if (gap_begin == 0) view.status = gbts_pkg::ST_START;
          else gap_begin--;
        end
        gbts_pkg::FUNC_MOVE: begin
          if (pos > text_length()) begin
            view.status = gbts_pkg::ST_BEYOND;
          end else begin
            while (gap_begin > pos) begin
              gap_begin--;
              gap_limit--;
              bytes[gap_limit] = bytes[gap_begin];
            end
            while (gap_begin < pos) begin
              bytes[gap_begin] = bytes[gap_limit];
              gap_begin++;
              gap_limit++;
            end
          end
        end
        default: ;
      endcase
      view.cursor = gbts_pkg::POS_W'(gap_begin);
      view.text_length = gbts_pkg::POS_W'(text_length());
      view.char_before = (gap_begin == 0) ? '0 : bytes[gap_begin - 1];
      expected_views.push_back(view);
    endfunction

    function void complain(string msg);
      if (failures < 10) $display("%s", msg);
      failures++;
    endfunction

    function void check_result(store_view_t got);
      store_view_t want;
      if (expected_views.size() == 0) begin
        complain($sformatf("unexpected result: status %0d cursor %0d length %0d char %02h",
                           got.status, got.cursor, got.text_length, got.char_before));
        return;
      end
      want = expected_views.pop_front();
      if (got.status !== want.status || got.cursor !== want.cursor ||
          got.text_length !== want.text_length || got.char_before !== want.char_before)
        complain($sformatf({"wrong result: expected status %0d cursor %0d length %0d ",
                            "char %02h, got status %0d cursor %0d length %0d char %02h"},
                           want.status, want.cursor, want.text_length, want.char_before,
                           got.status, got.cursor, got.text_length, got.char_before));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  gbts_request_if request_ch();
  gbts_result_if  result_ch();

  gap_buffer_text_store_core #(.CAPACITY(CAPACITY)) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gap_store_scoreboard board = new();

  int sender_idle_pct;
  int receiver_stall_pct;
  int pace_mode;
  int sent_in_pace;
  bit hold_pending;

  function void set_pace(int mode);
    pace_mode = mode;
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
      default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
    endcase
  endfunction

  task automatic send_request(gbts_pkg::func_t op, logic [gbts_pkg::CHAR_W-1:0] ch,
                              logic [gbts_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid    <= 1'b1;
    request_ch.func     <= op;
    request_ch.char_in  <= ch;
    request_ch.position <= pos;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    board.note_request(op, ch, pos);
    sent_in_pace++;
    if (sent_in_pace == 40) begin
      sent_in_pace = 0;
      set_pace((pace_mode + 1) % 4);
    end
  endtask

  function automatic logic [gbts_pkg::POS_W-1:0] pick_target();
    int unsigned len;
    int unsigned roll;
    len = board.text_length();
    roll = $urandom_range(99);
    if (roll < 60) return gbts_pkg::POS_W'($urandom_range(len, 0));
    if (roll < 70) return gbts_pkg::POS_W'(board.cursor_at());
    if (roll < 80) return '0;
    if (roll < 88) return gbts_pkg::POS_W'(len);
    return gbts_pkg::POS_W'($urandom_range(2047, len + 1));
  endfunction

  task automatic send_random(int insert_w, int delete_w, int move_w);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < insert_w)
      send_request(gbts_pkg::FUNC_INSERT, gbts_pkg::CHAR_W'($urandom),
                   gbts_pkg::POS_W'($urandom));
    else if (roll < insert_w + delete_w)
      send_request(gbts_pkg::FUNC_DELETE, gbts_pkg::CHAR_W'($urandom),
                   gbts_pkg::POS_W'($urandom));
    else if (roll < insert_w + delete_w + move_w)
      send_request(gbts_pkg::FUNC_MOVE, gbts_pkg::CHAR_W'($urandom), pick_target());
    else
      send_request(FUNC_IDLE, gbts_pkg::CHAR_W'($urandom), gbts_pkg::POS_W'($urandom));
  endtask

  initial begin : result_side
    store_view_t got;
    int hold;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.status      = result_ch.status;
        got.cursor      = result_ch.cursor;
        got.text_length = result_ch.text_length;
        got.char_before = result_ch.char_before_cursor;
        board.check_result(got);
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin : stimulus
    request_ch.valid    <= 1'b0;
    request_ch.func     <= gbts_pkg::FUNC_INSERT;
    request_ch.char_in  <= '0;
    request_ch.position <= '0;
    hold_pending = 1'b0;
    sent_in_pace = 0;
    set_pace(0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty store
    send_request(gbts_pkg::FUNC_DELETE, 8'hFF, 11'h7FF);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd1);
    send_request(gbts_pkg::FUNC_MOVE,   8'hFF, 11'h7FF);
    send_request(FUNC_IDLE,             8'hFF, 11'h7FF);
    send_request(gbts_pkg::FUNC_INSERT, 8'h00, 11'h7FF);
    send_request(gbts_pkg::FUNC_INSERT, 8'hFF, 11'h000);
    send_request(gbts_pkg::FUNC_INSERT, 8'h5A, 11'h555);
    send_request(gbts_pkg::FUNC_INSERT, 8'hA5, 11'h2AA);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd4);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd2);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd2);
    send_request(gbts_pkg::FUNC_INSERT, 8'h81, 11'd0);
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd1024);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd3);
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);

    repeat (60) send_random(35, 30, 30);

    // long receiver hold-off while requests keep coming
    set_pace(0);
    sent_in_pace = 0;
    hold_pending = 1'b1;
    repeat (120) send_random(90, 3, 6);

    send_request(gbts_pkg::FUNC_INSERT, 8'h3C, 11'd0);
    send_request(gbts_pkg::FUNC_INSERT, 8'hC3, 11'h7FF);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_INSERT, 8'h11, 11'd0);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, gbts_pkg::POS_W'(CAPACITY));
    send_request(gbts_pkg::FUNC_INSERT, 8'h22, 11'd0);
    send_request(gbts_pkg::FUNC_MOVE,   8'h00, gbts_pkg::POS_W'(CAPACITY + 1));
    send_request(gbts_pkg::FUNC_DELETE, 8'h00, 11'd0);
    send_request(gbts_pkg::FUNC_INSERT, 8'h7E, 11'd0);
    send_request(gbts_pkg::FUNC_INSERT, 8'hE7, 11'd0);

    repeat (120) send_random(45, 15, 35);
    repeat (250) send_random(30, 30, 35);

    request_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (board.failures == 0) begin
      $display("gap_buffer_text_store_core: match");
    end else begin
      $display("gap_buffer_text_store_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("gap_buffer_text_store_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
design/gbts_pkg.sv
design/gbts_if.sv
design/gap_buffer_text_store_core.sv
test/gap_buffer_text_store_core_test.sv
